@@ rtl/core/fnpll_pkg.sv @@
// Shared constants for the fractional-N PLL divider calculator.
// Holds register indexes, field widths and the fixed limits of the divider.
// No dependencies.
`default_nettype none

package fnpll_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_REF_FREQ    = 3'd0;
    localparam logic [2:0] CFG_SPACING     = 3'd1;
    localparam logic [2:0] CFG_DOUBLER     = 3'd2;
    localparam logic [2:0] CFG_HALVER      = 3'd3;
    localparam logic [2:0] CFG_R_DIVIDE    = 3'd4;
    localparam logic [2:0] CFG_PRESCALER   = 3'd5;
    localparam logic [2:0] CFG_FUNDAMENTAL = 3'd6;

    // Port widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Lowest VCO rate, 2200 MHz in Q16
    localparam logic [34:0] VCO_MIN_Q16 = 35'd144179200;
    // Highest output divider exponent
    localparam logic [2:0]  DIV_SEL_MAX = 3'd6;
    // INT limits
    localparam logic [15:0] INT_MAX_VAL = 16'hFFFF;
    localparam logic [15:0] INT_MIN_89  = 16'd75;
    localparam logic [15:0] INT_MIN_45  = 16'd23;

endpackage

`default_nettype wire

@@ rtl/core/frac_n_pll_divider_calc.sv @@
// Fractional-N PLL divider calculator: top level and bit-serial datapath.
// Turns a target frequency into the output divider, INT, FRAC and MOD words.
// Depends on fnpll_pkg.
//
// Usage: the input stream carries one target frequency per transfer
// (unsigned Q16 MHz). For each one the block returns a single result transfer
// holding the output divider exponent, INT, FRAC and MOD. Settings are written
// through the cfg port while the block is idle.
// The work is done by one shared shift-add multiplier (one multiplier bit per
// cycle) and one shared restoring divider (one quotient bit per cycle) that run
// in turn: feedback product, INT division (30 steps), spacing product, MOD
// division (32 steps), FRAC product and division (22 steps), a binary GCD (one
// step per cycle) and two 12-step reductions. One request is in work at a time;
// s_tready is high only while the datapath is free.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; the next result waits until that register is
// taken. Reset clears the control state and loads the default settings:
// 100 MHz reference, halver on, R of 1, 100 kHz spacing, 4/5 prescaler,
// fundamental feedback.
`default_nettype none

module frac_n_pll_divider_calc #(
    parameter int MOD_MAX = 4095
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // Request stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // s_tdata: [28:0] target_freq_q16, [31:29] zero
    input  wire  [fnpll_pkg::IN_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // m_tdata: [2:0] out_div_sel, [18:3] int_part, [30:19] frac_part,
    // [42:31] modulus, [47:43] zero
    output logic [fnpll_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration write port
    input  wire                               cfg_we,
    input  wire  [fnpll_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [fnpll_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fnpll_pkg::*;

    localparam logic [11:0] MOD_LIMIT = 12'(MOD_MAX);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KSEARCH,
        ST_MUL_N,
        ST_DIV_N,
        ST_MUL_S,
        ST_DIV_M,
        ST_MUL_F,
        ST_DIV_F,
        ST_GCD_INIT,
        ST_GCD,
        ST_RED_F,
        ST_RED_M,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [7:0]  ref_freq_reg;
    logic [19:0] spacing_reg;
    logic        doubler_reg;
    logic        halver_reg;
    logic [9:0]  r_divide_reg;
    logic        prescaler_reg;
    logic        fundamental_reg;

    // Request state
    logic [28:0] target_reg;
    logic [34:0] tshift_reg;
    logic [2:0]  k_reg;
    logic        sat_reg;
    logic [15:0] ival_reg;
    logic [15:0] num_lo_reg;
    logic [24:0] rem_reg;
    logic [11:0] mod_reg;
    logic [11:0] frac_reg;

    // Shift-add multiplier
    logic [46:0] acc_reg;
    logic [46:0] mcand_reg;
    logic [11:0] mplier_reg;

    // Restoring divider
    logic [31:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [31:0] prem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  dcnt_reg;

    // Binary GCD
    logic [11:0] ga_reg;
    logic [11:0] gb_reg;
    logic [3:0]  gsh_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Derived PFD terms
    logic [8:0]  pnum;
    logic [9:0]  r_eff;
    logic [10:0] pden;
    logic [20:0] pnum_x2000;
    logic [31:0] mod_dividend;

    assign pnum  = doubler_reg ? {ref_freq_reg, 1'b0} : {1'b0, ref_freq_reg};
    assign r_eff = (r_divide_reg == 10'd0) ? 10'd1 : r_divide_reg;
    assign pden  = halver_reg ? {r_eff, 1'b0} : {1'b0, r_eff};
    // 2000 = 2048 - 32 - 16
    assign pnum_x2000 = {1'b0, pnum, 11'd0} - {7'd0, pnum, 5'd0} - {8'd0, pnum, 4'd0};
    assign mod_dividend = {11'd0, pnum_x2000} + {1'b0, acc_reg[30:0]};

    // One restoring division step
    logic [32:0] div_shift;
    logic [32:0] div_diff;
    logic        div_ge;

    assign div_shift = {prem_reg, dvd_reg[31]};
    assign div_diff  = div_shift - {1'b0, dvs_reg};
    assign div_ge    = !div_diff[32];

    // Rounded frac product plus half the divisor
    logic [37:0] frac_sum;
    assign frac_sum = acc_reg[37:0] + {14'd0, pnum, 15'd0};

    // Clamped modulus from the MOD quotient
    logic [11:0] mod_clamped;
    always_comb
    begin
        if (quo_reg > {20'd0, MOD_LIMIT})
            mod_clamped = MOD_LIMIT;
        else if (quo_reg == 32'd0)
            mod_clamped = 12'd1;
        else
            mod_clamped = quo_reg[11:0];
    end

    // INT after the prescaler minimum
    logic [15:0] int_min;
    logic [15:0] int_out;
    assign int_min = prescaler_reg ? INT_MIN_89 : INT_MIN_45;
    assign int_out = (ival_reg < int_min) ? int_min : ival_reg;

    logic [11:0] gcd_val;
    assign gcd_val = ga_reg << gsh_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_freq_reg    <= 8'd100;
            spacing_reg     <= 20'd100;
            doubler_reg     <= 1'b0;
            halver_reg      <= 1'b1;
            r_divide_reg    <= 10'd1;
            prescaler_reg   <= 1'b0;
            fundamental_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_REF_FREQ:    ref_freq_reg    <= cfg_wdata[7:0];
                CFG_SPACING:     spacing_reg     <= cfg_wdata;
                CFG_DOUBLER:     doubler_reg     <= cfg_wdata[0];
                CFG_HALVER:      halver_reg      <= cfg_wdata[0];
                CFG_R_DIVIDE:    r_divide_reg    <= cfg_wdata[9:0];
                CFG_PRESCALER:   prescaler_reg   <= cfg_wdata[0];
                CFG_FUNDAMENTAL: fundamental_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Sequencer, shared multiplier and divider, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // The output state loads the register itself, so it is not cleared here.
            if (m_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        target_reg <= s_tdata[28:0];
                        tshift_reg <= {6'd0, s_tdata[28:0]};
                        k_reg      <= 3'd0;
                        state_reg  <= ST_KSEARCH;
                    end
                end

                // Smallest k with target * 2^k above the VCO minimum, at most DIV_SEL_MAX
                ST_KSEARCH:
                begin
                    if (k_reg == DIV_SEL_MAX || tshift_reg > VCO_MIN_Q16)
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= fundamental_reg ? {12'd0, tshift_reg}
                                                      : {18'd0, target_reg};
                        mplier_reg <= {1'b0, pden};
                        state_reg  <= ST_MUL_N;
                    end
                    else
                    begin
                        tshift_reg <= {tshift_reg[33:0], 1'b0};
                        k_reg      <= k_reg + 3'd1;
                    end
                end

                // Multiplier states run until the multiplier word is empty (ST_MUL_F stops early if INT saturated)
                ST_MUL_N:
                begin
                    if (mplier_reg == 12'd0)
                    begin
                        num_lo_reg <= acc_reg[15:0];
                        dvd_reg    <= {acc_reg[45:16], 2'b00};
                        dvs_reg    <= {23'd0, pnum};
                        prem_reg   <= '0;
                        quo_reg    <= '0;
                        dcnt_reg   <= 6'd30;
                        state_reg  <= ST_DIV_N;
                    end
                end

                ST_DIV_N:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        if (pnum == 9'd0 || quo_reg[29:16] != 14'd0)
                        begin
                            sat_reg  <= 1'b1;
                            ival_reg <= INT_MAX_VAL;
                        end
                        else
                        begin
                            sat_reg  <= 1'b0;
                            ival_reg <= quo_reg[15:0];
                        end
                        rem_reg    <= {prem_reg[8:0], num_lo_reg};
                        acc_reg    <= '0;
                        mcand_reg  <= {27'd0, spacing_reg};
                        mplier_reg <= {1'b0, pden};
                        state_reg  <= ST_MUL_S;
                    end
                end

                ST_MUL_S:
                begin
                    if (mplier_reg == 12'd0)
                    begin
                        if (spacing_reg == 20'd0)
                        begin
                            mod_reg    <= MOD_LIMIT;
                            acc_reg    <= '0;
                            mcand_reg  <= {22'd0, rem_reg};
                            mplier_reg <= MOD_LIMIT;
                            state_reg  <= ST_MUL_F;
                        end
                        else
                        begin
                            dvd_reg   <= mod_dividend;
                            dvs_reg   <= {acc_reg[30:0], 1'b0};
                            prem_reg  <= '0;
                            quo_reg   <= '0;
                            dcnt_reg  <= 6'd32;
                            state_reg <= ST_DIV_M;
                        end
                    end
                end

                ST_DIV_M:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        mod_reg    <= mod_clamped;
                        acc_reg    <= '0;
                        mcand_reg  <= {22'd0, rem_reg};
                        mplier_reg <= mod_clamped;
                        state_reg  <= ST_MUL_F;
                    end
                end

                ST_MUL_F:
                begin
                    if (sat_reg)
                    begin
                        frac_reg  <= 12'd0;
                        state_reg <= ST_GCD_INIT;
                    end
                    else if (mplier_reg == 12'd0)
                    begin
                        dvd_reg   <= {frac_sum[37:16], 10'd0};
                        dvs_reg   <= {23'd0, pnum};
                        prem_reg  <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= 6'd22;
                        state_reg <= ST_DIV_F;
                    end
                end

                ST_DIV_F:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        frac_reg  <= quo_reg[11:0];
                        state_reg <= ST_GCD_INIT;
                    end
                end

                // A zero FRAC reduces to 0 over 1
                ST_GCD_INIT:
                begin
                    ga_reg  <= frac_reg;
                    gb_reg  <= mod_reg;
                    gsh_reg <= 4'd0;
                    if (frac_reg == 12'd0)
                    begin
                        mod_reg   <= 12'd1;
                        state_reg <= ST_OUT;
                    end
                    else
                        state_reg <= ST_GCD;
                end

                // Binary GCD, one step per cycle
                ST_GCD:
                begin
                    if (ga_reg == gb_reg)
                    begin
                        dvd_reg   <= {frac_reg, 20'd0};
                        dvs_reg   <= {20'd0, gcd_val};
                        prem_reg  <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= 6'd12;
                        state_reg <= ST_RED_F;
                    end
                    else if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg  <= ga_reg >> 1;
                        gb_reg  <= gb_reg >> 1;
                        gsh_reg <= gsh_reg + 4'd1;
                    end
                    else if (!ga_reg[0])
                        ga_reg <= ga_reg >> 1;
                    else if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (ga_reg > gb_reg)
                        ga_reg <= ga_reg - gb_reg;
                    else
                        gb_reg <= gb_reg - ga_reg;
                end

                ST_RED_F:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        frac_reg  <= quo_reg[11:0];
                        dvd_reg   <= {mod_reg, 20'd0};
                        prem_reg  <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= 6'd12;
                        state_reg <= ST_RED_M;
                    end
                end

                ST_RED_M:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        mod_reg   <= quo_reg[11:0];
                        state_reg <= ST_OUT;
                    end
                end

                // Wait for the output register to be free
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, mod_reg, frac_reg, int_out, k_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase

            // Multiplier step: add the shifted multiplicand for each set bit
            if ((state_reg == ST_MUL_N || state_reg == ST_MUL_S ||
                 state_reg == ST_MUL_F) && mplier_reg != 12'd0)
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[45:0], 1'b0};
                mplier_reg <= mplier_reg >> 1;
            end

            // Divider step: one quotient bit per cycle
            if ((state_reg == ST_DIV_N || state_reg == ST_DIV_M ||
                 state_reg == ST_DIV_F || state_reg == ST_RED_F ||
                 state_reg == ST_RED_M) && dcnt_reg != 6'd0)
            begin
                prem_reg <= div_ge ? div_diff[31:0] : div_shift[31:0];
                quo_reg  <= {quo_reg[30:0], div_ge};
                dvd_reg  <= {dvd_reg[30:0], 1'b0};
                dcnt_reg <= dcnt_reg - 6'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/frac_n_pll_divider_calc_tb.sv @@
// Self-checking testbench for the fractional-N PLL divider calculator.
// Drives target frequencies through the request stream under several settings
// and checks every result against directed words or an in-bench divider solver.
// Depends on fnpll_pkg and frac_n_pll_divider_calc.
`default_nettype none

module frac_n_pll_divider_calc_tb;
    import fnpll_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 250;
    localparam longint unsigned VCO_Q16 = 64'd2200 * 64'd65536;
    localparam longint unsigned TARGET_TOP = 64'd288358400;

    typedef struct packed {
        logic [2:0]  div_sel;
        logic [15:0] int_word;
        logic [11:0] frac_word;
        logic [11:0] mod_word;
    } divider_words_t;

    typedef struct {
        logic [7:0]  ref_mhz;
        logic [19:0] spacing;
        logic        doubler;
        logic        halver;
        logic [9:0]  r_count;
        logic        presc;
        logic        fundamental;
    } pll_setup_t;

    typedef struct {
        logic [28:0]    target;
        bit             typed;
        divider_words_t words;
    } request_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pll_setup_t setup;
    divider_words_t pending_words[$];
    int mismatches = 0;
    int cycle_count = 0;
    bit steady_flow = 1'b0;

    frac_n_pll_divider_calc uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Exact rational solution of the divider words for one target.
    function automatic divider_words_t solve_divider(input logic [28:0] target);
        longint unsigned t, k, r, pnum, pden, tf, num, den, ival, rem, md, fr, a, b, tmp;
        longint unsigned sden;
        bit sat;
        divider_words_t w;
        t = 64'(target);
        k = 0;
        rem = 0;
        sat = 1'b0;
        while (k < 6 && !((t << k) > VCO_Q16))
            k++;
        r = (setup.r_count == 0) ? 64'd1 : 64'(setup.r_count);
        pnum = 64'(setup.ref_mhz) * (64'(setup.doubler) + 64'd1);
        pden = (64'(setup.halver) + 64'd1) * r;
        tf = setup.fundamental ? (t << k) : t;
        num = tf * pden;
        den = 64'd65536 * pnum;
        if (den == 0)
        begin
            sat = 1'b1;
            ival = 64'(INT_MAX_VAL);
        end
        else
        begin
            ival = num / den;
            rem = num % den;
            if (ival > 64'(INT_MAX_VAL))
            begin
                sat = 1'b1;
                ival = 64'(INT_MAX_VAL);
            end
        end
        // Modulus from the PFD rate over the channel spacing.
        if (setup.spacing == 0)
            md = 64'd4095;
        else
        begin
            sden = pden * 64'(setup.spacing);
            md = (64'd2000 * pnum + sden) / (64'd2 * sden);
            if (md > 64'd4095)
                md = 64'd4095;
        end
        if (md < 1)
            md = 64'd1;
        fr = sat ? 64'd0 : (64'd2 * md * rem + den) / (64'd2 * den);
        // Reduce the fraction by the greatest common divisor.
        a = fr;
        b = md;
        while (a != 0)
        begin
            tmp = b % a;
            b = a;
            a = tmp;
        end
        if (b == 0)
            b = 64'd1;
        fr = fr / b;
        md = md / b;
        if (setup.presc && ival < 64'(INT_MIN_89))
            ival = 64'(INT_MIN_89);
        else if (!setup.presc && ival < 64'(INT_MIN_45))
            ival = 64'(INT_MIN_45);
        w.div_sel = k[2:0];
        w.int_word = ival[15:0];
        w.frac_word = fr[11:0];
        w.mod_word = md[11:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // Writes all seven registers, one per cycle, while the block is idle.
    task automatic load_setup(input pll_setup_t s);
        logic [CFG_DATA_W-1:0] vals[7];
        vals[CFG_REF_FREQ] = 20'(s.ref_mhz);
        vals[CFG_SPACING] = s.spacing;
        vals[CFG_DOUBLER] = 20'(s.doubler);
        vals[CFG_HALVER] = 20'(s.halver);
        vals[CFG_R_DIVIDE] = 20'(s.r_count);
        vals[CFG_PRESCALER] = 20'(s.presc);
        vals[CFG_FUNDAMENTAL] = 20'(s.fundamental);
        for (int i = 0; i < 7; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= i[CFG_ADDR_W-1:0];
            cfg_wdata <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        setup = s;
    endtask

    // Sends one request; the expectation is queued when the transfer happens.
    task automatic send_request(input logic [28:0] target, input bit typed,
                                input divider_words_t words);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, target};
        do @(posedge clk); while (!s_tready);
        pending_words.push_back(typed ? words : solve_divider(target));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [28:0] pick_target();
        int k;
        case ($urandom_range(0, 3))
            0: return 29'($urandom_range(0, TARGET_TOP));
            1: return 29'($urandom & 32'h1FFF_FFFF);
            2:
            begin
                // Near the boundaries of the output divider choice.
                k = $urandom_range(0, 6);
                return 29'((VCO_Q16 >> k) + 64'($urandom_range(0, 2)) - 64'd1);
            end
            default: return 29'($urandom_range(0, 65536 * 200));
        endcase
    endfunction

    function automatic pll_setup_t pick_setup();
        pll_setup_t s;
        s.ref_mhz = 8'($urandom_range(1, 255));
        s.spacing = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 1000));
        s.doubler = 1'($urandom);
        s.halver = 1'($urandom);
        s.r_count = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(1, 8)) : 10'($urandom);
        s.presc = 1'($urandom);
        s.fundamental = 1'($urandom);
        return s;
    endfunction

    // Result side: random stalls, then check each transfer in order.
    initial
    begin
        divider_words_t want;
        divider_words_t got;
        int stall;
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.div_sel = m_tdata[2:0];
            got.int_word = m_tdata[18:3];
            got.frac_word = m_tdata[30:19];
            got.mod_word = m_tdata[42:31];
            if (pending_words.size() == 0)
                report_mismatch("unexpected result, tdata", longint'(m_tdata), 0);
            else
            begin
                want = pending_words.pop_front();
                if (got.div_sel != want.div_sel)
                    report_mismatch("out_div_sel", got.div_sel, want.div_sel);
                if (got.int_word != want.int_word)
                    report_mismatch("int_part", got.int_word, want.int_word);
                if (got.frac_word != want.frac_word)
                    report_mismatch("frac_part", got.frac_word, want.frac_word);
                if (got.mod_word != want.mod_word)
                    report_mismatch("modulus", got.mod_word, want.mod_word);
            end
        end
    end

    // Main sequence.
    initial
    begin
        request_row_t rows[$];
        pll_setup_t fixed_setups[4];
        divider_words_t none;
        none = '0;
        setup = '{8'd100, 20'd100, 1'b0, 1'b1, 10'd1, 1'b0, 1'b1};

        // Directed rows under the reset settings (50 MHz PFD, MOD 500).
        rows.push_back('{29'd0, 1'b1, '{3'd6, 16'd23, 12'd0, 12'd1}});
        rows.push_back('{29'd288358400, 1'b1, '{3'd0, 16'd88, 12'd0, 12'd1}});
        rows.push_back('{29'h1FFF_FFFF, 1'b0, none});
        rows.push_back('{29'd1, 1'b0, none});
        rows.push_back('{29'd144179200, 1'b0, none});
        rows.push_back('{29'd144179201, 1'b0, none});
        rows.push_back('{29'd72089600, 1'b0, none});
        rows.push_back('{29'd72089601, 1'b0, none});
        rows.push_back('{29'd2252800, 1'b0, none});
        rows.push_back('{29'd2252801, 1'b0, none});
        rows.push_back('{29'h1555_5555, 1'b0, none});
        rows.push_back('{29'h0AAA_AAAA, 1'b0, none});
        rows.push_back('{29'd200000000, 1'b0, none});
        rows.push_back('{29'd210000000, 1'b0, none});
        rows.push_back('{29'd180000001, 1'b0, none});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].target, rows[i].typed, rows[i].words);
        wait_idle();

        // Extremes: zero reference, zero spacing, zero R, tiny MOD, largest values.
        fixed_setups[0] = '{8'd250, 20'd1, 1'b1, 1'b0, 10'd1, 1'b1, 1'b0};
        fixed_setups[1] = '{8'd0, 20'd0, 1'b0, 1'b0, 10'd0, 1'b0, 1'b1};
        fixed_setups[2] = '{8'd255, 20'hFFFFF, 1'b0, 1'b1, 10'd1023, 1'b1, 1'b1};
        fixed_setups[3] = '{8'd100, 20'd1000000, 1'b0, 1'b1, 10'd1, 1'b0, 1'b1};
        foreach (fixed_setups[p])
        begin
            load_setup(fixed_setups[p]);
            for (int i = 0; i < 30; i++)
                send_request(pick_target(), 1'b0, none);
            wait_idle();
        end

        // Random settings, each with a burst of random targets.
        for (int p = 0; p < 6; p++)
        begin
            load_setup(pick_setup());
            steady_flow = (p == 2);
            for (int i = 0; i < 230; i++)
                send_request(pick_target(), 1'b0, none);
            wait_idle();
            steady_flow = 1'b0;
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
